>>> design/temq_pkg.sv
// shared types, codes and push routing tables for the timestamp event queues
// no dependencies
`default_nettype none

package temq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int NUM_QUEUES_DEF = 6;

    localparam int QIDX_W     = 3;
    localparam int SEC_W      = 64;
    localparam int FRAC_W     = 32;
    localparam int COUNT_W    = 7;
    localparam int FLAG_LSB   = 52;
    localparam int FLAG_W     = 5;
    localparam int STEP_W     = 3;
    localparam int PUSH_STEPS = 7;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    localparam logic [QIDX_W-1:0] Q_GPI0         = 3'd0;
    localparam logic [QIDX_W-1:0] Q_GPI1         = 3'd1;
    localparam logic [QIDX_W-1:0] Q_GPI2         = 3'd2;
    localparam logic [QIDX_W-1:0] Q_GPI3         = 3'd3;
    localparam logic [QIDX_W-1:0] Q_HOST         = 3'd4;
    localparam logic [QIDX_W-1:0] Q_HOST_OR_GPI0 = 3'd5;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [FRAC_W-1:0] frac;
    } t_rec;

    typedef struct packed {
        logic              put;
        logic              pop;
        logic              clr;
        logic [QIDX_W-1:0] q;
    } t_qcmd;

    function automatic logic [QIDX_W-1:0] push_step_queue(input logic [STEP_W-1:0] step);
        logic [QIDX_W-1:0] q;
        case (step)
            3'd0:    q = Q_HOST;
            3'd1:    q = Q_HOST_OR_GPI0;
            3'd2:    q = Q_GPI0;
            3'd3:    q = Q_HOST_OR_GPI0;
            3'd4:    q = Q_GPI1;
            3'd5:    q = Q_GPI2;
            default: q = Q_GPI3;
        endcase
        return q;
    endfunction

    function automatic logic [2:0] push_step_flag(input logic [STEP_W-1:0] step);
        logic [2:0] f;
        case (step)
            3'd0, 3'd1: f = 3'd0;
            3'd2, 3'd3: f = 3'd1;
            3'd4:       f = 3'd2;
            3'd5:       f = 3'd3;
            default:    f = 3'd4;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

>>> design/temq_store.sv
// record memory for all queues, one write and one registered read port
// depends on temq_pkg
`default_nettype none

module temq_store #(
    parameter int DEPTH      = temq_pkg::DEPTH_DEF,
    parameter int NUM_QUEUES = temq_pkg::NUM_QUEUES_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_we,
    input  wire  [$clog2(NUM_QUEUES*DEPTH)-1:0] i_waddr,
    input  temq_pkg::t_rec                    i_wdata,
    input  wire                               i_re,
    input  wire  [$clog2(NUM_QUEUES*DEPTH)-1:0] i_raddr,
    output temq_pkg::t_rec                    o_rdata
);

    localparam int WORDS = NUM_QUEUES * DEPTH;

    temq_pkg::t_rec r_mem [WORDS];
    temq_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/temq_qstate.sv
// per-queue write pointer, read pointer and fill count with one shared step unit
// depends on temq_pkg
`default_nettype none

module temq_qstate #(
    parameter int DEPTH      = temq_pkg::DEPTH_DEF,
    parameter int NUM_QUEUES = temq_pkg::NUM_QUEUES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  temq_pkg::t_qcmd              i_cmd,
    output logic                         o_valid,
    output logic [$clog2(DEPTH)-1:0]     o_wp,
    output logic [$clog2(DEPTH)-1:0]     o_rp,
    output logic [$clog2(DEPTH+1)-1:0]   o_cnt,
    output logic [$clog2(DEPTH+1)-1:0]   o_nxt_cnt
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int QW = $clog2(NUM_QUEUES);

    logic [PW-1:0] r_wp  [NUM_QUEUES];
    logic [PW-1:0] r_rp  [NUM_QUEUES];
    logic [CW-1:0] r_cnt [NUM_QUEUES];

    logic [QW-1:0] idx;
    logic [PW-1:0] sel_ptr;
    logic [PW-1:0] nxt_ptr;

    assign idx     = i_cmd.q[QW-1:0];
    assign o_valid = (int'(i_cmd.q) < NUM_QUEUES);

    always_comb begin
        o_wp  = '0;
        o_rp  = '0;
        o_cnt = '0;
        if (o_valid) begin
            o_wp  = r_wp[idx];
            o_rp  = r_rp[idx];
            o_cnt = r_cnt[idx];
        end
    end

    // shared pointer / count step
    assign sel_ptr   = i_cmd.put ? o_wp : o_rp;
    assign nxt_ptr   = (sel_ptr == PW'(DEPTH - 1)) ? '0 : sel_ptr + 1'b1;
    assign o_nxt_cnt = i_cmd.put ? o_cnt + 1'b1 : o_cnt - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_wp[i]  <= '0;
                r_rp[i]  <= '0;
                r_cnt[i] <= '0;
            end
        end else if (o_valid) begin
            if (i_cmd.clr) begin
                r_wp[idx]  <= '0;
                r_rp[idx]  <= '0;
                r_cnt[idx] <= '0;
            end else if (i_cmd.put) begin
                // full queue drops the beat
                if (o_cnt != CW'(DEPTH)) begin
                    r_wp[idx]  <= nxt_ptr;
                    r_cnt[idx] <= o_nxt_cnt;
                end
            end else if (i_cmd.pop) begin
                if (o_cnt != '0) begin
                    r_rp[idx]  <= nxt_ptr;
                    r_cnt[idx] <= o_nxt_cnt;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/timestamp_event_multi_queue.sv
// timestamp event queues: a push runs one routing step per cycle over seven steps
// (six queues, the combined queue twice), then o_done; pop, count and clear run
// the execute state, then o_done. one item at a time; o_busy is high after
// acceptance through the o_done cycle. o_done marks the single result beat.
// synchronous active-low reset empties every queue; record memory is not cleared.
// depends on temq_pkg, temq_qstate, temq_store
`default_nettype none

module timestamp_event_multi_queue #(
    parameter int DEPTH      = temq_pkg::DEPTH_DEF,
    parameter int NUM_QUEUES = temq_pkg::NUM_QUEUES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    output logic                             o_busy,
    input  wire  [1:0]                       i_kind,
    input  wire  [temq_pkg::QIDX_W-1:0]      i_queue_index,
    input  wire  [temq_pkg::SEC_W-1:0]       i_super_seconds,
    input  wire  [temq_pkg::FRAC_W-1:0]      i_sub_seconds,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [temq_pkg::SEC_W-1:0]       o_out_super_seconds,
    output logic [temq_pkg::FRAC_W-1:0]      o_out_sub_seconds,
    output logic [temq_pkg::COUNT_W-1:0]     o_queue_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(NUM_QUEUES * DEPTH);
    localparam int XW = (CW > temq_pkg::COUNT_W) ? CW : temq_pkg::COUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PUSH = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [1:0]                          r_kind;
    logic [temq_pkg::QIDX_W-1:0]         r_q;
    temq_pkg::t_rec                      r_rec;
    logic [temq_pkg::STEP_W-1:0]         r_step, n_step;
    logic [1:0]                          r_status, n_status;
    logic [CW-1:0]                       r_cnt, n_cnt;
    logic                                r_popped, n_popped;

    temq_pkg::t_qcmd                     qcmd;
    logic                                q_valid;
    logic [PW-1:0]                       q_wp, q_rp;
    logic [CW-1:0]                       q_cnt, q_nxt_cnt;
    logic                                mem_we, mem_re;
    logic [AW-1:0]                       mem_waddr, mem_raddr;
    temq_pkg::t_rec                      mem_rdata;
    logic [temq_pkg::FLAG_W-1:0]         flags;
    logic [XW-1:0]                       cnt_ext;
    logic                                q_full;

    assign flags  = r_rec.sec[temq_pkg::FLAG_LSB +: temq_pkg::FLAG_W];
    assign q_full = (q_cnt == CW'(DEPTH));

    // queue command from registered state only; full and empty are gated in u_qstate
    assign qcmd = '{
        put: (r_state == S_PUSH) && flags[temq_pkg::push_step_flag(r_step)],
        pop: (r_state == S_EXEC) && (r_kind == temq_pkg::KIND_POP),
        clr: (r_state == S_EXEC) && (r_kind == temq_pkg::KIND_CLEAR),
        q:   (r_state == S_PUSH) ? temq_pkg::push_step_queue(r_step) : r_q
    };

    assign mem_we = qcmd.put && q_valid && !q_full;
    assign mem_re = qcmd.pop && q_valid && (q_cnt != '0);

    temq_qstate #(
        .DEPTH      (DEPTH),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_qstate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (qcmd),
        .o_valid   (q_valid),
        .o_wp      (q_wp),
        .o_rp      (q_rp),
        .o_cnt     (q_cnt),
        .o_nxt_cnt (q_nxt_cnt)
    );

    temq_store #(
        .DEPTH      (DEPTH),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_rec),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign mem_waddr = AW'(DEPTH * int'(qcmd.q) + int'(q_wp));
    assign mem_raddr = AW'(DEPTH * int'(qcmd.q) + int'(q_rp));

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_status = r_status;
        n_cnt    = r_cnt;
        n_popped = r_popped;
        unique case (r_state)
            S_IDLE: begin
                n_step   = '0;
                n_status = temq_pkg::ST_OK;
                n_cnt    = '0;
                n_popped = 1'b0;
                if (i_start) begin
                    n_state = (i_kind == temq_pkg::KIND_PUSH) ? S_PUSH : S_EXEC;
                end
            end
            S_PUSH: begin
                n_step = r_step + 1'b1;
                if (r_step == temq_pkg::STEP_W'(temq_pkg::PUSH_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (!q_valid) begin
                    n_status = temq_pkg::ST_BAD_INDEX;
                end else begin
                    case (r_kind)
                        temq_pkg::KIND_POP: begin
                            if (q_cnt == '0) begin
                                n_status = temq_pkg::ST_EMPTY;
                            end else begin
                                n_cnt    = q_nxt_cnt;
                                n_popped = 1'b1;
                            end
                        end
                        temq_pkg::KIND_COUNT: begin
                            n_cnt = q_cnt;
                        end
                        default: begin
                            n_cnt = '0;
                        end
                    endcase
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_status <= temq_pkg::ST_OK;
            r_cnt    <= '0;
            r_popped <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_status <= n_status;
            r_cnt    <= n_cnt;
            r_popped <= n_popped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_kind   <= i_kind;
            r_q      <= i_queue_index;
            r_rec    <= '{sec: i_super_seconds, frac: i_sub_seconds};
        end
    end

    assign cnt_ext             = XW'(r_cnt);
    assign o_busy              = (r_state != S_IDLE);
    assign o_done              = (r_state == S_DONE);
    assign o_status            = r_status;
    assign o_out_super_seconds = r_popped ? mem_rdata.sec : '0;
    assign o_out_sub_seconds   = r_popped ? mem_rdata.frac : '0;
    assign o_queue_count       = cnt_ext[temq_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

>>> verif/temq_result_checker.sv
// result checker for the timestamp event queues: watches start/busy and done beats,
// keeps its own copy of the six ring queues and compares every done beat in order
// depends on temq_pkg
module temq_result_checker
    import temq_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_busy,
    input  wire  [1:0]          i_kind,
    input  wire  [QIDX_W-1:0]   i_queue_index,
    input  wire  [SEC_W-1:0]    i_super_seconds,
    input  wire  [FRAC_W-1:0]   i_sub_seconds,
    input  wire                 i_done,
    input  wire  [1:0]          i_status,
    input  wire  [SEC_W-1:0]    i_out_super_seconds,
    input  wire  [FRAC_W-1:0]   i_out_sub_seconds,
    input  wire  [COUNT_W-1:0]  i_queue_count,
    output int                  o_pending,
    output int                  o_fail_count,
    output int                  o_checked,
    output int                  o_drops,
    output int                  o_empty_pops,
    output int                  o_max_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ         = NUM_QUEUES_DEF;
    localparam int QDEPTH     = DEPTH_DEF;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        logic [1:0]         status;
        logic [SEC_W-1:0]   sec;
        logic [FRAC_W-1:0]  frac;
        logic [COUNT_W-1:0] count;
    } t_result;

    t_rec    rec_mem [NQ][QDEPTH];
    int      wr_ptr [NQ];
    int      rd_ptr [NQ];
    int      fill [NQ];
    t_result expected_beats [$];

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (o_fail_count < PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    function automatic void store_copy(int q, t_rec r);
        if (fill[q] >= QDEPTH) begin
            o_drops++;
        end else begin
            rec_mem[q][wr_ptr[q]] = r;
            wr_ptr[q] = (wr_ptr[q] + 1) % QDEPTH;
            fill[q]++;
            if (fill[q] > o_max_fill) begin
                o_max_fill = fill[q];
            end
        end
    endfunction

    function automatic t_result apply_queue_op(logic [1:0] kind, logic [QIDX_W-1:0] q, t_rec r);
        t_result           res;
        logic [FLAG_W-1:0] flags;
        res   = '0;
        res.status = ST_OK;
        flags = r.sec[FLAG_LSB +: FLAG_W];
        if (kind == KIND_PUSH) begin
            // host copy first, then gpi0; the combined queue takes one copy from each
            if (flags[0]) begin
                store_copy(Q_HOST, r);
                store_copy(Q_HOST_OR_GPI0, r);
            end
            if (flags[1]) begin
                store_copy(Q_GPI0, r);
                store_copy(Q_HOST_OR_GPI0, r);
            end
            if (flags[2]) begin
                store_copy(Q_GPI1, r);
            end
            if (flags[3]) begin
                store_copy(Q_GPI2, r);
            end
            if (flags[4]) begin
                store_copy(Q_GPI3, r);
            end
        end else if (q >= NQ) begin
            res.status = ST_BAD_INDEX;
        end else if (kind == KIND_POP) begin
            if (fill[q] == 0) begin
                res.status = ST_EMPTY;
                o_empty_pops++;
            end else begin
                res.sec   = rec_mem[q][rd_ptr[q]].sec;
                res.frac  = rec_mem[q][rd_ptr[q]].frac;
                rd_ptr[q] = (rd_ptr[q] + 1) % QDEPTH;
                fill[q]--;
                res.count = COUNT_W'(fill[q]);
            end
        end else if (kind == KIND_COUNT) begin
            res.count = COUNT_W'(fill[q]);
        end else begin
            wr_ptr[q] = 0;
            rd_ptr[q] = 0;
            fill[q]   = 0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_rec    pushed;
        if (!i_rst_n) begin
            for (int q = 0; q < NQ; q++) begin
                wr_ptr[q] = 0;
                rd_ptr[q] = 0;
                fill[q]   = 0;
            end
            expected_beats.delete();
        end else begin
            if (i_done) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("done beat with nothing expected", i_status, 0);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch("status", i_status, want.status);
                    end
                    if (i_out_super_seconds !== want.sec) begin
                        report_mismatch("out_super_seconds", i_out_super_seconds, want.sec);
                    end
                    if (i_out_sub_seconds !== want.frac) begin
                        report_mismatch("out_sub_seconds", i_out_sub_seconds, want.frac);
                    end
                    if (i_queue_count !== want.count) begin
                        report_mismatch("queue_count", i_queue_count, want.count);
                    end
                    o_checked++;
                end
            end
            if (i_start && !i_busy) begin
                pushed.sec  = i_super_seconds;
                pushed.frac = i_sub_seconds;
                expected_beats.push_back(apply_queue_op(i_kind, i_queue_index, pushed));
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

>>> verif/timestamp_event_multi_queue_test.sv
// top of the timestamp event queue testbench: clock, reset, directed and random command
// beats with random idle gaps, and the verdict; checking is done in temq_result_checker
// depends on temq_pkg, temq_result_checker and timestamp_event_multi_queue
module timestamp_event_multi_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import temq_pkg::*;

    localparam int RAND_ITEMS   = 1900;
    localparam int MAX_GAP      = 13;
    localparam int END_SETTLE   = 16;
    localparam int RUN_LIMIT_NS = 20_000_000;

    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    localparam int IDLE_NONE   = 0;
    localparam int IDLE_FULL   = 1;
    localparam int IDLE_SPARSE = 2;

    localparam logic [QIDX_W-1:0] Q_FIRST_BAD = QIDX_W'(NUM_QUEUES_DEF);
    localparam logic [QIDX_W-1:0] Q_LAST_BAD  = '1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [1:0]         i_kind = KIND_COUNT;
    logic [QIDX_W-1:0]  i_queue_index = '0;
    logic [SEC_W-1:0]   i_super_seconds = '0;
    logic [FRAC_W-1:0]  i_sub_seconds = '0;
    logic               o_busy;
    logic               o_done;
    logic [1:0]         o_status;
    logic [SEC_W-1:0]   o_out_super_seconds;
    logic [FRAC_W-1:0]  o_out_sub_seconds;
    logic [COUNT_W-1:0] o_queue_count;

    int pending;
    int fail_count;
    int checked;
    int drops;
    int empty_pops;
    int max_fill;
    int directed_sent;
    int random_sent;
    int drain_waits;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    timestamp_event_multi_queue u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_kind              (i_kind),
        .i_queue_index       (i_queue_index),
        .i_super_seconds     (i_super_seconds),
        .i_sub_seconds       (i_sub_seconds),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_out_super_seconds (o_out_super_seconds),
        .o_out_sub_seconds   (o_out_sub_seconds),
        .o_queue_count       (o_queue_count)
    );

    temq_result_checker u_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .i_busy              (o_busy),
        .i_kind              (i_kind),
        .i_queue_index       (i_queue_index),
        .i_super_seconds     (i_super_seconds),
        .i_sub_seconds       (i_sub_seconds),
        .i_done              (o_done),
        .i_status            (o_status),
        .i_out_super_seconds (o_out_super_seconds),
        .i_out_sub_seconds   (o_out_sub_seconds),
        .i_queue_count       (o_queue_count),
        .o_pending           (pending),
        .o_fail_count        (fail_count),
        .o_checked           (checked),
        .o_drops             (drops),
        .o_empty_pops        (empty_pops),
        .o_max_fill          (max_fill)
    );

    function automatic logic [SEC_W-1:0] rand_seconds(logic [FLAG_W-1:0] flags);
        logic [SEC_W-1:0] s;
        s = {$urandom, $urandom};
        s[FLAG_LSB +: FLAG_W] = flags;
        return s;
    endfunction

    function automatic int draw_gap(int style);
        int gap;
        case (style)
            IDLE_NONE: begin
                gap = 0;
            end
            IDLE_FULL: begin
                gap = $urandom_range(0, MAX_GAP);
            end
            default: begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            end
        endcase
        return gap;
    endfunction

    // returns at the falling edge before the accepting rising edge
    task automatic send_beat(int gap, logic [1:0] kind, logic [QIDX_W-1:0] q,
                             logic [SEC_W-1:0] sec, logic [FRAC_W-1:0] frac);
        repeat (gap) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start         <= 1'b1;
        i_kind          <= kind;
        i_queue_index   <= q;
        i_super_seconds <= sec;
        i_sub_seconds   <= frac;
        while (o_busy) begin
            @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        drain_waits++;
    endtask

    task automatic send_random_beat(int mix, int gap);
        int                push_pct;
        int                pop_pct;
        int                count_pct;
        int                roll;
        logic [1:0]        kind;
        logic [QIDX_W-1:0] q;
        case (mix)
            MIX_FILL: begin
                push_pct = 80; pop_pct = 12; count_pct = 6;
            end
            MIX_DRAIN: begin
                push_pct = 8; pop_pct = 77; count_pct = 10;
            end
            default: begin
                push_pct = 40; pop_pct = 40; count_pct = 12;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            kind = KIND_PUSH;
        end else if (roll < push_pct + pop_pct) begin
            kind = KIND_POP;
        end else if (roll < push_pct + pop_pct + count_pct) begin
            kind = KIND_COUNT;
        end else begin
            kind = KIND_CLEAR;
        end
        if ($urandom_range(0, 9) == 0) begin
            q = QIDX_W'($urandom_range(int'(Q_FIRST_BAD), int'(Q_LAST_BAD)));
        end else begin
            q = QIDX_W'($urandom_range(0, NUM_QUEUES_DEF - 1));
        end
        send_beat(gap, kind, q, rand_seconds(FLAG_W'($urandom)), $urandom);
    endtask

    initial begin
        int bursts;
        int burst_len;
        int mix;
        int idle_style;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queues, bad indexes, extreme records, one flag at a time
        send_beat(draw_gap(IDLE_FULL), KIND_COUNT, Q_GPI0, '1, '1);
        send_beat(draw_gap(IDLE_FULL), KIND_POP, Q_GPI0, '0, '0);
        send_beat(draw_gap(IDLE_FULL), KIND_POP, Q_FIRST_BAD, '1, '1);
        send_beat(draw_gap(IDLE_FULL), KIND_COUNT, Q_LAST_BAD, '0, '0);
        send_beat(draw_gap(IDLE_FULL), KIND_CLEAR, Q_FIRST_BAD, '1, '1);
        send_beat(draw_gap(IDLE_FULL), KIND_PUSH, Q_LAST_BAD, '1, '1);
        send_beat(draw_gap(IDLE_FULL), KIND_PUSH, Q_GPI0, '0, '0);
        directed_sent = 7;
        for (int b = 0; b < FLAG_W; b++) begin
            send_beat(draw_gap(IDLE_FULL), KIND_PUSH, QIDX_W'($urandom),
                      rand_seconds(FLAG_W'(1) << b), $urandom);
            directed_sent++;
        end
        send_beat(draw_gap(IDLE_FULL), KIND_COUNT, Q_HOST_OR_GPI0, '0, '0);
        directed_sent++;
        for (int q = 0; q < NUM_QUEUES_DEF; q++) begin
            send_beat(draw_gap(IDLE_FULL), KIND_POP, QIDX_W'(q), '1, '1);
            directed_sent++;
        end
        send_beat(draw_gap(IDLE_FULL), KIND_CLEAR, Q_HOST_OR_GPI0, '1, '1);
        send_beat(draw_gap(IDLE_FULL), KIND_COUNT, Q_HOST_OR_GPI0, '0, '0);
        send_beat(draw_gap(IDLE_FULL), KIND_POP, Q_HOST_OR_GPI0, '1, '1);
        send_beat(draw_gap(IDLE_FULL), KIND_POP, Q_GPI1, '1, '1);
        directed_sent += 4;
        drain_results();

        bursts = 0;
        while (random_sent < RAND_ITEMS) begin
            burst_len  = $urandom_range(40, 120);
            mix        = (bursts < 2) ? MIX_FILL : $urandom_range(MIX_FILL, MIX_EVEN);
            idle_style = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            for (int n = 0; n < burst_len && random_sent < RAND_ITEMS; n++) begin
                send_random_beat(mix, draw_gap(idle_style));
                random_sent++;
            end
            if (bursts == 0 || $urandom_range(0, 3) == 0) begin
                drain_results();
            end
            bursts++;
        end

        drain_results();
        repeat (END_SETTLE) @(negedge i_clk);
        $display("covered %0d directed and %0d random command beats, %0d done beats checked",
                 directed_sent, random_sent, checked);
        $display("deepest fill %0d of %0d, %0d copies dropped when full, %0d empty pops, %0d drains",
                 max_fill, DEPTH_DEF, drops, empty_pops, drain_waits);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d done beats still outstanding", pending);
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
design/temq_pkg.sv
design/temq_store.sv
design/temq_qstate.sv
design/timestamp_event_multi_queue.sv
verif/temq_result_checker.sv
verif/timestamp_event_multi_queue_test.sv
